// ===== design/bgag_pkg.sv =====
// ----------------------------------------------------------------------------
// bgag_pkg
// Shared constants, types and the edge padding table of the block gather
// address generator.
// ----------------------------------------------------------------------------
package bgag_pkg;

    localparam int COORD_BITS_DEF  = 21;
    localparam int OFFSET_BITS_DEF = 48;

    localparam int INDEX_BITS  = 54;
    localparam int STRIDE_BITS = 41;
    localparam int POS_BITS    = 6;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // divider retires this many quotient bits per cycle
    localparam int DIV_RADIX_BITS = 3;
    localparam int DIV_STEPS      = INDEX_BITS / DIV_RADIX_BITS;
    localparam int DIV_STEP_W     = $clog2(DIV_STEPS);

    // base offset multiplier takes this many coordinate bits per cycle
    localparam int MUL_CHUNK = 16;

    // front/back queue, depth a power of two
    localparam int QUEUE_DEPTH = 2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_SIZE_X   = 3'd0;
    localparam reg_idx_t REG_SIZE_Y   = 3'd1;
    localparam reg_idx_t REG_SIZE_Z   = 3'd2;
    localparam reg_idx_t REG_STRIDE_X = 3'd3;
    localparam reg_idx_t REG_STRIDE_Y = 3'd4;
    localparam reg_idx_t REG_STRIDE_Z = 3'd5;

    // fold code: padding table row, or no folding on that axis
    typedef logic [1:0] fold_code_t;
    localparam fold_code_t FOLD_NONE = 2'd3;

    typedef struct packed {
        fold_code_t x;
        fold_code_t y;
        fold_code_t z;
    } fold_set_t;

    localparam int FOLD_TAB [3][4] = '{
        '{0,  0,  0, -3},
        '{0,  0, -1, -3},
        '{0, -1, -2, -3}
    };

    // element index within the block -> sample index after padding
    function automatic logic [1:0] fold_map(input fold_code_t code, input logic [1:0] idx);
        if (code == FOLD_NONE) begin
            return idx;
        end
        return 2'(int'(idx) + FOLD_TAB[code][idx]);
    endfunction

endpackage

// ===== design/bgag_cfg.sv =====
// ----------------------------------------------------------------------------
// bgag_cfg
// Register file behind the APB-style port, plus the effective strides
// (zero stride replaced by its dense default).
// ----------------------------------------------------------------------------
module bgag_cfg
    import bgag_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic [COORD_BITS-1:0]  size_x,
    output logic [COORD_BITS-1:0]  size_y,
    output logic [COORD_BITS-1:0]  size_z,
    output logic [OFFSET_BITS-1:0] step_x,
    output logic [OFFSET_BITS-1:0] step_y,
    output logic [OFFSET_BITS-1:0] step_z
);

    logic [COORD_BITS-1:0]    size_reg [3];
    logic [STRIDE_BITS-1:0]   stride_reg [3];
    logic [2*COORD_BITS-1:0]  area_reg;
    logic [OFFSET_BITS-1:0]   step_reg [3];
    logic [OFFSET_BITS-1:0]   step_next [3];

    logic                     wr_en;
    reg_idx_t                 reg_idx;

    logic [OFFSET_BITS+STRIDE_BITS-1:0]  sext_x_w, sext_y_w, sext_z_w;
    logic [OFFSET_BITS+COORD_BITS-1:0]   nx_w;
    logic [OFFSET_BITS+2*COORD_BITS-1:0] area_w;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg[0]   <= COORD_BITS'(4);
            size_reg[1]   <= COORD_BITS'(4);
            size_reg[2]   <= COORD_BITS'(4);
            stride_reg[0] <= '0;
            stride_reg[1] <= '0;
            stride_reg[2] <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SIZE_X:   size_reg[0]   <= pwdata[COORD_BITS-1:0];
                REG_SIZE_Y:   size_reg[1]   <= pwdata[COORD_BITS-1:0];
                REG_SIZE_Z:   size_reg[2]   <= pwdata[COORD_BITS-1:0];
                REG_STRIDE_X: stride_reg[0] <= pwdata[STRIDE_BITS-1:0];
                REG_STRIDE_Y: stride_reg[1] <= pwdata[STRIDE_BITS-1:0];
                REG_STRIDE_Z: stride_reg[2] <= pwdata[STRIDE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sign / zero extension to offset width, wrapping where narrower
    assign sext_x_w = {{OFFSET_BITS{stride_reg[0][STRIDE_BITS-1]}}, stride_reg[0]};
    assign sext_y_w = {{OFFSET_BITS{stride_reg[1][STRIDE_BITS-1]}}, stride_reg[1]};
    assign sext_z_w = {{OFFSET_BITS{stride_reg[2][STRIDE_BITS-1]}}, stride_reg[2]};
    assign nx_w     = {{OFFSET_BITS{1'b0}}, size_reg[0]};
    assign area_w   = {{OFFSET_BITS{1'b0}}, area_reg};

    always_comb
    begin
        step_next[0] = (stride_reg[0] != '0) ? sext_x_w[OFFSET_BITS-1:0] : OFFSET_BITS'(1);
        step_next[1] = (stride_reg[1] != '0) ? sext_y_w[OFFSET_BITS-1:0] : nx_w[OFFSET_BITS-1:0];
        step_next[2] = (stride_reg[2] != '0) ? sext_z_w[OFFSET_BITS-1:0]
                                             : area_w[OFFSET_BITS-1:0];
    end

    // registered derived values: the area from the extents, then the steps from strides and area
    always_ff @(posedge clk)
    begin
        area_reg    <= size_reg[0] * size_reg[1];
        step_reg[0] <= step_next[0];
        step_reg[1] <= step_next[1];
        step_reg[2] <= step_next[2];
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SIZE_X:   prdata = CFG_DATA_W'(size_reg[0]);
            REG_SIZE_Y:   prdata = CFG_DATA_W'(size_reg[1]);
            REG_SIZE_Z:   prdata = CFG_DATA_W'(size_reg[2]);
            REG_STRIDE_X: prdata = {{(CFG_DATA_W-STRIDE_BITS){stride_reg[0][STRIDE_BITS-1]}},
                                    stride_reg[0]};
            REG_STRIDE_Y: prdata = {{(CFG_DATA_W-STRIDE_BITS){stride_reg[1][STRIDE_BITS-1]}},
                                    stride_reg[1]};
            REG_STRIDE_Z: prdata = {{(CFG_DATA_W-STRIDE_BITS){stride_reg[2][STRIDE_BITS-1]}},
                                    stride_reg[2]};
            default:      prdata = '0;
        endcase
    end

    assign size_x = size_reg[0];
    assign size_y = size_reg[1];
    assign size_z = size_reg[2];
    assign step_x = step_reg[0];
    assign step_y = step_reg[1];
    assign step_z = step_reg[2];

endmodule

// ===== design/bgag_front.sv =====
// ----------------------------------------------------------------------------
// bgag_front
// Splits a block index into block origins (two radix-8 divisions), works
// out the padding code per axis and the block base offset (chunked
// multiply-accumulate), then hands the block to the queue.
// ----------------------------------------------------------------------------
module bgag_front
    import bgag_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [INDEX_BITS-1:0]  block_index,
    input  logic [COORD_BITS-1:0]  size_x,
    input  logic [COORD_BITS-1:0]  size_y,
    input  logic [COORD_BITS-1:0]  size_z,
    input  logic [OFFSET_BITS-1:0] step_x,
    input  logic [OFFSET_BITS-1:0] step_y,
    input  logic [OFFSET_BITS-1:0] step_z,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [OFFSET_BITS-1:0] q_base,
    output fold_set_t              q_fold
);

    localparam int DW     = COORD_BITS - 1;   // block count width
    localparam int RW     = COORD_BITS - 2;   // block remainder width
    localparam int NCHUNK = (OFFSET_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MW     = NCHUNK * MUL_CHUNK;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_DIV1 = 6'b000010,
        F_DIV2 = 6'b000100,
        F_PREP = 6'b001000,
        F_MUL  = 6'b010000,
        F_DONE = 6'b100000
    } fstate_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    fstate_t                st_reg, st_next;
    logic [DIV_STEP_W-1:0]  step_cnt_reg, step_cnt_next;
    logic [CW-1:0]          chunk_reg, chunk_next;
    axis_t                  axis_reg, axis_next;

    logic [INDEX_BITS-1:0]  quo_reg, quo_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [RW-1:0]          rx_reg, rx_next;
    logic [RW-1:0]          ry_reg, ry_next;
    fold_set_t              fold_reg, fold_next;
    logic [MW-1:0]          coord_sh_reg, coord_sh_next;
    logic [OFFSET_BITS-1:0] stride_sh_reg, stride_sh_next;
    logic [OFFSET_BITS-1:0] acc_reg, acc_next;

    logic                   accept;
    logic [COORD_BITS:0]    nx_up, ny_up;
    logic [DW-1:0]          bx_raw, by_raw, bx, by, div_d;
    logic [INDEX_BITS-1:0]  q_w;
    logic [DW-1:0]          r_w;
    logic [DW:0]            part_w;

    logic [COORD_BITS-1:0]  ox, oy, oz_lo;
    logic                   oz_big;
    logic [MW+COORD_BITS-1:0]   ox_w, oy_w;
    logic [MW+INDEX_BITS+1:0]   oz_w;
    logic [OFFSET_BITS-1:0] prod_w;

    function automatic fold_code_t fold_code(input logic [COORD_BITS-1:0] org,
                                             input logic [COORD_BITS-1:0] n);
        logic [COORD_BITS:0] top_w;
        logic [COORD_BITS:0] row_w;
        top_w = {1'b0, org} + (COORD_BITS+1)'(3);
        row_w = top_w - {1'b0, n};
        if ((org < n) && (top_w >= {1'b0, n})) begin
            return row_w[1:0];
        end
        return FOLD_NONE;
    endfunction

    // block counts per axis, a zero extent counts as one block
    assign nx_up  = {1'b0, size_x} + (COORD_BITS+1)'(3);
    assign ny_up  = {1'b0, size_y} + (COORD_BITS+1)'(3);
    assign bx_raw = nx_up[COORD_BITS:2];
    assign by_raw = ny_up[COORD_BITS:2];
    assign bx     = (bx_raw == '0) ? DW'(1) : bx_raw;
    assign by     = (by_raw == '0) ? DW'(1) : by_raw;
    assign div_d  = (st_reg == F_DIV2) ? by : bx;

    // restoring division, DIV_RADIX_BITS quotient bits per cycle
    always_comb
    begin
        q_w    = quo_reg;
        r_w    = rem_reg;
        part_w = '0;
        for (int k = 0; k < DIV_RADIX_BITS; k++)
        begin
            part_w = {r_w, q_w[INDEX_BITS-1]};
            q_w    = {q_w[INDEX_BITS-2:0], 1'b0};
            if (part_w >= {1'b0, div_d})
            begin
                r_w    = DW'(part_w - {1'b0, div_d});
                q_w[0] = 1'b1;
            end
            else
            begin
                r_w = part_w[DW-1:0];
            end
        end
    end

    // block origins
    assign ox     = {rx_reg, 2'b00};
    assign oy     = {ry_reg, 2'b00};
    assign oz_lo  = {quo_reg[RW-1:0], 2'b00};
    assign oz_big = |quo_reg[INDEX_BITS-1:RW];
    assign ox_w   = {{MW{1'b0}}, ox};
    assign oy_w   = {{MW{1'b0}}, oy};
    assign oz_w   = {{MW{1'b0}}, quo_reg, 2'b00};

    assign prod_w = OFFSET_BITS'(coord_sh_reg[MUL_CHUNK-1:0]) * stride_sh_reg;

    assign q_push   = (st_reg == F_DONE) && !q_full;
    assign in_ready = (st_reg == F_IDLE) || q_push;
    assign accept   = in_valid && in_ready;
    assign q_base   = acc_reg;
    assign q_fold   = fold_reg;

    always_comb
    begin
        st_next        = st_reg;
        step_cnt_next  = step_cnt_reg;
        chunk_next     = chunk_reg;
        axis_next      = axis_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        fold_next      = fold_reg;
        coord_sh_next  = coord_sh_reg;
        stride_sh_next = stride_sh_reg;
        acc_next       = acc_reg;

        unique case (st_reg)
            F_IDLE: ;
            F_DIV1:
            begin
                quo_next      = q_w;
                rem_next      = r_w;
                step_cnt_next = DIV_STEP_W'(step_cnt_reg + 1'b1);
                if (step_cnt_reg == DIV_STEP_W'(DIV_STEPS - 1))
                begin
                    rx_next       = r_w[RW-1:0];
                    rem_next      = '0;
                    step_cnt_next = '0;
                    st_next       = F_DIV2;
                end
            end
            F_DIV2:
            begin
                quo_next      = q_w;
                rem_next      = r_w;
                step_cnt_next = DIV_STEP_W'(step_cnt_reg + 1'b1);
                if (step_cnt_reg == DIV_STEP_W'(DIV_STEPS - 1))
                begin
                    ry_next       = r_w[RW-1:0];
                    step_cnt_next = '0;
                    st_next       = F_PREP;
                end
            end
            F_PREP:
            begin
                fold_next.x    = fold_code(ox, size_x);
                fold_next.y    = fold_code(oy, size_y);
                fold_next.z    = oz_big ? FOLD_NONE : fold_code(oz_lo, size_z);
                coord_sh_next  = ox_w[MW-1:0];
                stride_sh_next = step_x;
                axis_next      = AX_X;
                chunk_next     = '0;
                acc_next       = '0;
                st_next        = F_MUL;
            end
            F_MUL:
            begin
                acc_next       = acc_reg + prod_w;
                coord_sh_next  = coord_sh_reg >> MUL_CHUNK;
                stride_sh_next = stride_sh_reg << MUL_CHUNK;
                chunk_next     = CW'(chunk_reg + 1'b1);
                if (chunk_reg == CW'(NCHUNK - 1))
                begin
                    chunk_next = '0;
                    unique case (axis_reg)
                        AX_X:
                        begin
                            coord_sh_next  = oy_w[MW-1:0];
                            stride_sh_next = step_y;
                            axis_next      = AX_Y;
                        end
                        AX_Y:
                        begin
                            coord_sh_next  = oz_w[MW-1:0];
                            stride_sh_next = step_z;
                            axis_next      = AX_Z;
                        end
                        default:
                        begin
                            st_next = F_DONE;
                        end
                    endcase
                end
            end
            F_DONE:
            begin
                if (q_push)
                begin
                    st_next = F_IDLE;
                end
            end
            default:
            begin
                st_next = F_IDLE;
            end
        endcase

        // a new block may start in the same cycle the last one is handed over
        if (accept)
        begin
            st_next       = F_DIV1;
            quo_next      = block_index;
            rem_next      = '0;
            step_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= F_IDLE;
            step_cnt_reg <= '0;
            chunk_reg    <= '0;
            axis_reg     <= AX_X;
        end
        else
        begin
            st_reg       <= st_next;
            step_cnt_reg <= step_cnt_next;
            chunk_reg    <= chunk_next;
            axis_reg     <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        rx_reg        <= rx_next;
        ry_reg        <= ry_next;
        fold_reg      <= fold_next;
        coord_sh_reg  <= coord_sh_next;
        stride_sh_reg <= stride_sh_next;
        acc_reg       <= acc_next;
    end

endmodule

// ===== design/bgag_queue.sv =====
// ----------------------------------------------------------------------------
// bgag_queue
// Short queue of prepared blocks between the front and the back.
// ----------------------------------------------------------------------------
module bgag_queue
    import bgag_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = CNT_W'(count_reg + 1'b1);
            2'b01:   count_next = CNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    // pointers wrap on their own, depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/bgag_back.sv =====
// ----------------------------------------------------------------------------
// bgag_back
// Walks the 64 elements of the block at the queue head, one per cycle
// while the output is not stalled: base + z term + y term in the first
// stage, + x term into the output register.
// ----------------------------------------------------------------------------
module bgag_back
    import bgag_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  logic [OFFSET_BITS-1:0]        q_base,
    input  fold_set_t                     q_fold,
    output logic                          q_pop,
    input  logic [OFFSET_BITS-1:0]        step_x,
    input  logic [OFFSET_BITS-1:0]        step_y,
    input  logic [OFFSET_BITS-1:0]        step_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OFFSET_BITS-1:0] element_offset,
    output logic [POS_BITS-1:0]           element_pos,
    output logic                          last_of_block
);

    logic [OFFSET_BITS-1:0] trip_reg [3];

    logic [POS_BITS-1:0]    cnt_reg;
    logic                   s1_valid_reg;
    logic [OFFSET_BITS-1:0] s1_sum_reg;
    logic [1:0]             s1_jx_reg;
    logic [POS_BITS-1:0]    s1_pos_reg;

    logic                   out_valid_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic [POS_BITS-1:0]    out_pos_reg;
    logic                   out_last_reg;

    logic                   s1_ready, s2_ready, issue;
    logic [1:0]             jx, jy, jz;
    logic [OFFSET_BITS-1:0] s1_sum_next;

    // j * stride for j in 0..3
    function automatic logic [OFFSET_BITS-1:0] term(input logic [1:0] j,
                                                    input logic [OFFSET_BITS-1:0] s,
                                                    input logic [OFFSET_BITS-1:0] s3);
        logic [OFFSET_BITS-1:0] t;
        unique case (j)
            2'd0: t = '0;
            2'd1: t = s;
            2'd2: t = s << 1;
            2'd3: t = s3;
        endcase
        return t;
    endfunction

    always_ff @(posedge clk)
    begin
        trip_reg[0] <= step_x + (step_x << 1);
        trip_reg[1] <= step_y + (step_y << 1);
        trip_reg[2] <= step_z + (step_z << 1);
    end

    assign s2_ready = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign issue    = q_valid && s1_ready;
    assign q_pop    = issue && (&cnt_reg);

    assign jx = fold_map(q_fold.x, cnt_reg[1:0]);
    assign jy = fold_map(q_fold.y, cnt_reg[3:2]);
    assign jz = fold_map(q_fold.z, cnt_reg[5:4]);

    assign s1_sum_next = q_base + term(jy, step_y, trip_reg[1]) + term(jz, step_z, trip_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                cnt_reg <= POS_BITS'(cnt_reg + 1'b1);
            end
            if (s1_ready)
            begin
                s1_valid_reg <= issue;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_sum_reg <= s1_sum_next;
            s1_jx_reg  <= jx;
            s1_pos_reg <= cnt_reg;
        end
        if (s2_ready && s1_valid_reg)
        begin
            out_offset_reg <= s1_sum_reg + term(s1_jx_reg, step_x, trip_reg[0]);
            out_pos_reg    <= s1_pos_reg;
            out_last_reg   <= &s1_pos_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign element_offset = out_offset_reg;
    assign element_pos    = out_pos_reg;
    assign last_of_block  = out_last_reg;

endmodule

// ===== design/block_gather_address_generator_3d.sv =====
// ----------------------------------------------------------------------------
// block_gather_address_generator_3d
// Turns a linear 4x4x4 block index into the 64 element offsets of that
// block, with edge padding on partial blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Program extents and strides over the APB-style port while idle (a zero
//   stride selects the dense default). Each input beat carries one block
//   index; the block yields 64 output beats, x fastest, then y, then z,
//   with last_of_block on the 64th.
//   The first offset of a block waits on the front: the radix-8 divider
//   and the 16-bit multiply-accumulate for the block base, then the back
//   end's first stage and its output register.
//   Throughput: one offset per cycle while the receiver does not stall, set
//   by the back end walking the block. The front prepares the next block while
//   the back emits the current one, with a two-entry queue between them.
//   Reset: extents 4, strides 0, queue and pipeline empty.
//   Receiver stall: the output register holds its beat, the back end
//   stops, the queue fills and in_ready drops once the front holds a
//   finished block with nowhere to put it.
// ----------------------------------------------------------------------------
module block_gather_address_generator_3d
    import bgag_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_W-1:0]         paddr,
    input  logic [CFG_DATA_W-1:0]         pwdata,
    output logic [CFG_DATA_W-1:0]         prdata,
    output logic                          pready,
    // block index beats
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [INDEX_BITS-1:0]         block_index,
    // offset beats
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OFFSET_BITS-1:0] element_offset,
    output logic [POS_BITS-1:0]           element_pos,
    output logic                          last_of_block
);

    localparam int ENTRY_W = OFFSET_BITS + $bits(fold_set_t);

    logic [COORD_BITS-1:0]  size_x, size_y, size_z;
    logic [OFFSET_BITS-1:0] step_x, step_y, step_z;

    logic                   q_push, q_full, q_pop, q_valid;
    logic [OFFSET_BITS-1:0] q_base_wr, q_base_rd;
    fold_set_t              q_fold_wr, q_fold_rd;
    logic [ENTRY_W-1:0]     q_wr_data, q_rd_data;

    assign pready = 1'b1;

    bgag_cfg #(
        .COORD_BITS  (COORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .size_x  (size_x),
        .size_y  (size_y),
        .size_z  (size_z),
        .step_x  (step_x),
        .step_y  (step_y),
        .step_z  (step_z)
    );

    // front: origins, padding codes and base offset per block
    bgag_front #(
        .COORD_BITS  (COORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .block_index (block_index),
        .size_x      (size_x),
        .size_y      (size_y),
        .size_z      (size_z),
        .step_x      (step_x),
        .step_y      (step_y),
        .step_z      (step_z),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_base      (q_base_wr),
        .q_fold      (q_fold_wr)
    );

    assign q_wr_data              = {q_base_wr, q_fold_wr};
    assign {q_base_rd, q_fold_rd} = q_rd_data;

    bgag_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .rd_valid  (q_valid),
        .rd_data   (q_rd_data)
    );

    // back: 64 offsets per block, one per cycle unless the output stalls
    bgag_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_base         (q_base_rd),
        .q_fold         (q_fold_rd),
        .q_pop          (q_pop),
        .step_x         (step_x),
        .step_y         (step_y),
        .step_z         (step_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .element_offset (element_offset),
        .element_pos    (element_pos),
        .last_of_block  (last_of_block)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("block pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("block popped from an empty queue");

    a_last_on_final_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_block == (&element_pos)))
        else $error("last_of_block does not match the final element position");

    a_front_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("front took a second beat while dividing");
`endif

endmodule
